// ===== sv/mlss_pkg.sv =====
// Shared types and codes for the monitor link service sequencer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package mlss_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned STATE_W = 4;
  localparam int unsigned LINK_W  = 3;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned STS_W   = 2;
  localparam int unsigned CFG_IDX_W = 8;

  // Service states
  localparam logic [STATE_W-1:0] ST_BOOT    = 4'd0;
  localparam logic [STATE_W-1:0] ST_WAKE    = 4'd1;
  localparam logic [STATE_W-1:0] ST_CONFIG  = 4'd2;
  localparam logic [STATE_W-1:0] ST_START   = 4'd3;
  localparam logic [STATE_W-1:0] ST_WAIT    = 4'd4;
  localparam logic [STATE_W-1:0] ST_READ    = 4'd5;
  localparam logic [STATE_W-1:0] ST_PROCESS = 4'd6;
  localparam logic [STATE_W-1:0] ST_STANDBY = 4'd7;
  localparam logic [STATE_W-1:0] ST_SLEEP   = 4'd8;
  localparam logic [STATE_W-1:0] ST_FAULT   = 4'd9;

  // Link states
  localparam logic [LINK_W-1:0] LK_OFF   = 3'd0;
  localparam logic [LINK_W-1:0] LK_IDLE  = 3'd1;
  localparam logic [LINK_W-1:0] LK_READY = 3'd2;
  localparam logic [LINK_W-1:0] LK_XFER  = 3'd3;
  localparam logic [LINK_W-1:0] LK_ERROR = 3'd4;

  // Operations performed in a tick
  localparam logic [ACT_W-1:0] ACT_NONE      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_WAKE      = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CONFIG    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_START     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ      = 3'd4;
  localparam logic [ACT_W-1:0] ACT_WAKE_READ = 3'd5;

  // Status codes
  localparam logic [STS_W-1:0] STS_OK       = 2'd0;
  localparam logic [STS_W-1:0] STS_COMM_ERR = 2'd1;
  localparam logic [STS_W-1:0] STS_BAD_ST   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_PERIOD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_TIMEOUT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONV_TIME      = 8'd3;

  // Register reset values
  localparam logic [LIMIT_W-1:0] MEASURE_PERIOD_RST = 16'd100;
  localparam logic [LIMIT_W-1:0] IDLE_TIMEOUT_RST   = 16'd5;
  localparam logic [LIMIT_W-1:0] SLEEP_TIMEOUT_RST  = 16'd2000;
  localparam logic [LIMIT_W-1:0] CONV_TIME_RST      = 16'd8;

  typedef struct packed {
    logic [LIMIT_W-1:0] measure_period;
    logic [LIMIT_W-1:0] idle_timeout;
    logic [LIMIT_W-1:0] sleep_timeout;
    logic [LIMIT_W-1:0] conv_time;
  } limits_t;

  typedef struct packed {
    logic [STATE_W-1:0] svc_state;
    logic [LINK_W-1:0]  link;
    logic               configured;
    logic [TIME_W-1:0]  last_comm;
    logic [TIME_W-1:0]  last_meas;
    logic [TIME_W-1:0]  entry_time;
    logic [CNT_W-1:0]   meas_cnt;
    logic [CNT_W-1:0]   err_cnt;
  } seq_state_t;

  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic              wake_ok;
    logic              xfer_ok;
  } tick_t;

endpackage

// ===== sv/mlss_cfg_regs.sv =====
// Limit registers of the service sequencer, written through the config channel.
// Depends on mlss_pkg.
`timescale 1ns / 1ps

module mlss_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [mlss_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [mlss_pkg::LIMIT_W-1:0]   wr_data,
  output mlss_pkg::limits_t              limits
);
  import mlss_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.measure_period <= MEASURE_PERIOD_RST;
      limits.idle_timeout   <= IDLE_TIMEOUT_RST;
      limits.sleep_timeout  <= SLEEP_TIMEOUT_RST;
      limits.conv_time      <= CONV_TIME_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_MEASURE_PERIOD: limits.measure_period <= wr_data;
        REG_IDLE_TIMEOUT:   limits.idle_timeout   <= wr_data;
        REG_SLEEP_TIMEOUT:  limits.sleep_timeout  <= wr_data;
        REG_CONV_TIME:      limits.conv_time      <= wr_data;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

endmodule

// ===== sv/mlss_step.sv =====
// Next-state logic for one service tick: transitions, operations, status, counters.
// Depends on mlss_pkg.
`timescale 1ns / 1ps

module mlss_step (
  input  mlss_pkg::seq_state_t       cur,
  input  mlss_pkg::tick_t            tick,
  input  mlss_pkg::limits_t          limits,
  output mlss_pkg::seq_state_t       nxt,
  output logic [mlss_pkg::ACT_W-1:0] action,
  output logic [mlss_pkg::STS_W-1:0] status
);
  import mlss_pkg::*;

  logic [TIME_W-1:0] since_comm;
  logic [TIME_W-1:0] since_meas;
  logic [TIME_W-1:0] since_entry;
  logic              idle_hit;
  logic              sleep_hit;
  logic              period_hit;
  logic              conv_done;

  assign since_comm  = tick.now - cur.last_comm;
  assign since_meas  = tick.now - cur.last_meas;
  assign since_entry = tick.now - cur.entry_time;

  assign idle_hit   = since_comm  >= {{(TIME_W-LIMIT_W){1'b0}}, limits.idle_timeout};
  assign sleep_hit  = since_comm  >= {{(TIME_W-LIMIT_W){1'b0}}, limits.sleep_timeout};
  assign period_hit = since_meas  >= {{(TIME_W-LIMIT_W){1'b0}}, limits.measure_period};
  assign conv_done  = since_entry >  {{(TIME_W-LIMIT_W){1'b0}}, limits.conv_time};

  always_comb begin
    logic fault;
    fault  = 1'b0;
    nxt    = cur;
    action = ACT_NONE;
    status = STS_OK;

    case (cur.svc_state)
      ST_BOOT: begin
        nxt.configured = 1'b0;
        nxt.link       = LK_IDLE;
        nxt.entry_time = tick.now;
        nxt.svc_state  = ST_WAKE;
      end
      ST_STANDBY: begin
        if (period_hit) begin
          if (sleep_hit) begin
            nxt.configured = 1'b0;
            nxt.svc_state  = ST_WAKE;
          end else if (idle_hit) begin
            nxt.svc_state = ST_WAKE;
          end else begin
            nxt.svc_state = ST_START;
          end
          nxt.entry_time = tick.now;
        end
      end
      ST_WAKE: begin
        action = ACT_WAKE;
        if (tick.wake_ok) begin
          nxt.link       = LK_READY;
          nxt.last_comm  = tick.now;
          nxt.entry_time = tick.now;
          nxt.svc_state  = cur.configured ? ST_START : ST_CONFIG;
        end else begin
          fault = 1'b1;
        end
      end
      ST_CONFIG: begin
        action       = ACT_CONFIG;
        nxt.meas_cnt = '0;
        nxt.err_cnt  = '0;
        if (tick.xfer_ok) begin
          nxt.configured = 1'b1;
          nxt.link       = LK_READY;
          nxt.last_comm  = tick.now;
          nxt.entry_time = tick.now;
          nxt.svc_state  = ST_START;
        end else begin
          nxt.configured = 1'b0;
          fault          = 1'b1;
        end
      end
      ST_START: begin
        if (sleep_hit) begin
          nxt.configured = 1'b0;
          nxt.svc_state  = ST_WAKE;
        end else if (idle_hit) begin
          nxt.svc_state = ST_WAKE;
        end else begin
          action = ACT_START;
          if (tick.xfer_ok) begin
            nxt.link       = LK_XFER;
            nxt.last_comm  = tick.now;
            nxt.entry_time = tick.now;
            nxt.meas_cnt   = cur.meas_cnt + 1'b1;
            nxt.svc_state  = ST_WAIT;
          end else begin
            fault = 1'b1;
          end
        end
      end
      ST_WAIT: begin
        if (conv_done) begin
          if (idle_hit) begin
            action = ACT_WAKE;
            if (!tick.wake_ok) begin
              fault = 1'b1;
            end else begin
              nxt.link       = LK_READY;
              nxt.last_comm  = tick.now;
              nxt.entry_time = tick.now;
              nxt.svc_state  = ST_READ;
            end
          end else begin
            nxt.svc_state = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (sleep_hit) begin
          nxt.configured = 1'b0;
          nxt.svc_state  = ST_WAKE;
        end else if (idle_hit && !tick.wake_ok) begin
          action = ACT_WAKE;  // wake failed, read skipped
          fault  = 1'b1;
        end else begin
          action = idle_hit ? ACT_WAKE_READ : ACT_READ;
          if (tick.xfer_ok) begin
            nxt.link      = LK_READY;
            nxt.last_comm = tick.now;
            nxt.last_meas = tick.now;
            nxt.svc_state = ST_PROCESS;
          end else begin
            // a successful wake still refreshes the comm time
            if (idle_hit) begin
              nxt.last_comm = tick.now;
            end
            fault = 1'b1;
          end
        end
      end
      ST_PROCESS: begin
        nxt.svc_state = ST_STANDBY;
      end
      ST_SLEEP: begin
        if (period_hit) begin
          nxt.configured = 1'b0;
          nxt.svc_state  = ST_WAKE;
        end
      end
      ST_FAULT: begin
        nxt.configured = 1'b0;
        nxt.link       = LK_ERROR;
        nxt.entry_time = tick.now;
        nxt.svc_state  = ST_WAKE;
      end
      default: begin
        nxt.configured = 1'b0;
        nxt.svc_state  = ST_FAULT;
        status         = STS_BAD_ST;
      end
    endcase

    if (fault) begin
      nxt.err_cnt   = nxt.err_cnt + 1'b1;
      nxt.link      = LK_ERROR;
      nxt.svc_state = ST_FAULT;
      status        = STS_COMM_ERR;
    end
  end

endmodule

// ===== sv/monitor_link_service_sequencer.sv =====
// Top level of the battery-monitor chain service sequencer.
// Depends on mlss_pkg, mlss_cfg_regs and mlss_step.
`timescale 1ns / 1ps

//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | now_ms, wake_ok, xfer_ok
//  out     | out_valid / out_ready| next_state, link_mode, is_configured, action,
//          |                      | status, measure_total, comm_error_total
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (16 bit limit)
//
// One tick per clock sustained while out_ready is high. A tick accepted lands in the input
// register, is evaluated against the sequencer state, and its result is registered in the
// result register and shown on the out port.
// Reset is synchronous; it empties both registers, restores the limits to
// their defaults and puts the sequencer in boot with cleared times and counts.
// If out_ready stays low the result beat holds, the input register fills with
// the next tick, and in_ready drops until the result is taken.
// cfg_ready is always high; a write to an unmapped index is accepted and dropped.

module monitor_link_service_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  // tick input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mlss_pkg::TIME_W-1:0]    now_ms,
  input  logic                           wake_ok,
  input  logic                           xfer_ok,
  // result output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mlss_pkg::STATE_W-1:0]   next_state,
  output logic [mlss_pkg::LINK_W-1:0]    link_mode,
  output logic                           is_configured,
  output logic [mlss_pkg::ACT_W-1:0]     action,
  output logic [mlss_pkg::STS_W-1:0]     status,
  output logic [mlss_pkg::CNT_W-1:0]     measure_total,
  output logic [mlss_pkg::CNT_W-1:0]     comm_error_total,
  // limit register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mlss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlss_pkg::LIMIT_W-1:0]   cfg_data
);
  import mlss_pkg::*;

  limits_t            limits;
  tick_t              tick;       // input register payload
  logic               tick_full;  // input register holds a beat
  seq_state_t         seq;        // sequencer state
  seq_state_t         seq_next;
  logic [ACT_W-1:0]   step_action;
  logic [STS_W-1:0]   step_status;
  logic               advance;    // input beat moves to the result register

  assign cfg_ready = 1'b1;

  mlss_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .limits   (limits)
  );

  mlss_step u_step (
    .cur    (seq),
    .tick   (tick),
    .limits (limits),
    .nxt    (seq_next),
    .action (step_action),
    .status (step_status)
  );

  // Result register frees up when empty or being drained this cycle.
  assign advance  = tick_full && (!out_valid || out_ready);
  assign in_ready = !tick_full || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_full <= 1'b0;
    end else if (in_ready) begin
      tick_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tick.now     <= now_ms;
      tick.wake_ok <= wake_ok;
      tick.xfer_ok <= xfer_ok;
    end
  end

  // Sequencer state commits once per evaluated tick
  always_ff @(posedge clk) begin
    if (rst) begin
      seq.svc_state  <= ST_BOOT;
      seq.link       <= LK_OFF;
      seq.configured <= 1'b0;
      seq.last_comm  <= '0;
      seq.last_meas  <= '0;
      seq.entry_time <= '0;
      seq.meas_cnt   <= '0;
      seq.err_cnt    <= '0;
    end else if (advance) begin
      seq <= seq_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= tick_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      next_state       <= seq_next.svc_state;
      link_mode        <= seq_next.link;
      is_configured    <= seq_next.configured;
      action           <= step_action;
      status           <= step_status;
      measure_total    <= seq_next.meas_cnt;
      comm_error_total <= seq_next.err_cnt;
    end
  end

endmodule

// ===== sv/mlss_checker.sv =====
// Port-level checks for the service sequencer, bound to the top level.
// Depends on mlss_pkg and monitor_link_service_sequencer.
`timescale 1ns / 1ps

module mlss_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mlss_pkg::STATE_W-1:0]   next_state,
  input logic [mlss_pkg::LINK_W-1:0]    link_mode,
  input logic                           is_configured,
  input logic [mlss_pkg::ACT_W-1:0]     action,
  input logic [mlss_pkg::STS_W-1:0]     status,
  input logic [mlss_pkg::CNT_W-1:0]     measure_total,
  input logic [mlss_pkg::CNT_W-1:0]     comm_error_total
);
  import mlss_pkg::*;

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_state) && $stable(action)
      && $stable(measure_total) && $stable(comm_error_total))
    else $error("result beat changed while stalled");

  // A communication failure always lands in fault with the link in error.
  a_comm_err_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STS_COMM_ERR |-> next_state == ST_FAULT && link_mode == LK_ERROR)
    else $error("comm error without fault");

  // A good configure leaves the chain configured with a cleared error count.
  a_cfg_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_CONFIG && status == STS_OK
      |-> is_configured && comm_error_total == '0 && measure_total == '0)
    else $error("configure success not reflected");

  // Configure is only entered while unconfigured.
  a_cfg_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && next_state == ST_CONFIG |-> !is_configured)
    else $error("configure entered while configured");

  // No result beat in the first cycle out of reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind monitor_link_service_sequencer mlss_checker u_mlss_checker (.*);

// ===== tb/monitor_link_service_sequencer_tb.sv =====
// Self-checking testbench for the monitor link service sequencer.
// Depends on mlss_pkg and monitor_link_service_sequencer.
`timescale 1ns / 1ps

module monitor_link_service_sequencer_tb;
  import mlss_pkg::*;

  // One tick beat as the sender holds it
  typedef struct {
    logic [TIME_W-1:0] now;
    logic              wake;
    logic              xfer;
  } tick_beat_t;

  // One predicted result beat
  typedef struct {
    logic [STATE_W-1:0] state;
    logic [LINK_W-1:0]  link;
    logic               cfgd;
    logic [ACT_W-1:0]   act;
    logic [STS_W-1:0]   sts;
    logic [CNT_W-1:0]   meas;
    logic [CNT_W-1:0]   errs;
  } tick_result_t;

  // Index with no register behind it; the block takes the beat and drops it
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd4;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [TIME_W-1:0]    now_ms = '0;
  logic                 wake_ok = 1'b0;
  logic                 xfer_ok = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATE_W-1:0]   next_state;
  logic [LINK_W-1:0]    link_mode;
  logic                 is_configured;
  logic [ACT_W-1:0]     action;
  logic [STS_W-1:0]     status;
  logic [CNT_W-1:0]     measure_total;
  logic [CNT_W-1:0]     comm_error_total;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_data = '0;

  monitor_link_service_sequencer DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .now_ms           (now_ms),
    .wake_ok          (wake_ok),
    .xfer_ok          (xfer_ok),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .next_state       (next_state),
    .link_mode        (link_mode),
    .is_configured    (is_configured),
    .action           (action),
    .status           (status),
    .measure_total    (measure_total),
    .comm_error_total (comm_error_total),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Bookkeeping shared by the stimulus, the driver and the monitor
  tick_beat_t   tick_backlog[$];     // ticks waiting to be driven
  tick_result_t pending_results[$];  // predictions waiting for their result beat
  int           ticks_total  = 0;    // ticks handed to the driver so far
  int           results_seen = 0;    // result beats taken so far
  int           mismatch_cnt = 0;
  int           gap_pct      = 36;   // chance in percent that a side idles this cycle
  logic [TIME_W-1:0] sim_ms  = '0;   // running millisecond clock for random ticks

  // Predictor copy of the limit registers
  logic [LIMIT_W-1:0] lim_period = MEASURE_PERIOD_RST;
  logic [LIMIT_W-1:0] lim_idle   = IDLE_TIMEOUT_RST;
  logic [LIMIT_W-1:0] lim_sleep  = SLEEP_TIMEOUT_RST;
  logic [LIMIT_W-1:0] lim_conv   = CONV_TIME_RST;

  // Predictor copy of the sequencer state (reset values)
  logic [STATE_W-1:0] chain_state     = ST_BOOT;
  logic [LINK_W-1:0]  chain_link      = LK_OFF;
  logic               chain_cfgd      = 1'b0;
  logic [TIME_W-1:0]  chain_last_comm = '0;
  logic [TIME_W-1:0]  chain_last_meas = '0;
  logic [TIME_W-1:0]  chain_entry     = '0;
  logic [CNT_W-1:0]   chain_meas_cnt  = '0;
  logic [CNT_W-1:0]   chain_err_cnt   = '0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Any failed wake or transfer: count it and park the chain in fault.
  function automatic void take_comm_fault();
    chain_err_cnt = chain_err_cnt + 1'b1;
    chain_link    = LK_ERROR;
    chain_state   = ST_FAULT;
  endfunction

  // Run one service tick through the predictor and return the result it gives.
  function automatic tick_result_t advance_chain(input logic [TIME_W-1:0] now,
                                                 input logic wk, input logic xf);
    logic [TIME_W-1:0] since_comm;
    logic [TIME_W-1:0] since_meas;
    logic [TIME_W-1:0] in_state;
    tick_result_t      r;
    // all elapsed times wrap modulo 2^32
    since_comm = now - chain_last_comm;
    since_meas = now - chain_last_meas;
    in_state   = now - chain_entry;
    r.act = ACT_NONE;
    r.sts = STS_OK;
    case (chain_state)
      ST_BOOT: begin
        chain_cfgd  = 1'b0;
        chain_link  = LK_IDLE;
        chain_entry = now;
        chain_state = ST_WAKE;
      end
      ST_STANDBY: begin
        if (since_meas >= lim_period) begin
          if (since_comm >= lim_sleep) begin
            chain_cfgd  = 1'b0;
            chain_state = ST_WAKE;
          end else if (since_comm >= lim_idle) begin
            chain_state = ST_WAKE;
          end else begin
            chain_state = ST_START;
          end
          chain_entry = now;
        end
      end
      ST_WAKE: begin
        r.act = ACT_WAKE;
        if (wk) begin
          chain_link      = LK_READY;
          chain_last_comm = now;
          chain_entry     = now;
          chain_state     = chain_cfgd ? ST_START : ST_CONFIG;
        end else begin
          r.sts = STS_COMM_ERR;
          take_comm_fault();
        end
      end
      ST_CONFIG: begin
        // a configure attempt always starts from cleared counts
        r.act          = ACT_CONFIG;
        chain_meas_cnt = '0;
        chain_err_cnt  = '0;
        if (xf) begin
          chain_cfgd      = 1'b1;
          chain_link      = LK_READY;
          chain_last_comm = now;
          chain_entry     = now;
          chain_state     = ST_START;
        end else begin
          chain_cfgd = 1'b0;
          r.sts      = STS_COMM_ERR;
          take_comm_fault();
        end
      end
      ST_START: begin
        if (since_comm >= lim_sleep) begin
          chain_cfgd  = 1'b0;
          chain_state = ST_WAKE;
        end else if (since_comm >= lim_idle) begin
          chain_state = ST_WAKE;
        end else begin
          r.act = ACT_START;
          if (xf) begin
            chain_link      = LK_XFER;
            chain_last_comm = now;
            chain_entry     = now;
            chain_meas_cnt  = chain_meas_cnt + 1'b1;
            chain_state     = ST_WAIT;
          end else begin
            r.sts = STS_COMM_ERR;
            take_comm_fault();
          end
        end
      end
      ST_WAIT: begin
        if (in_state > lim_conv) begin
          if (since_comm >= lim_idle) begin
            // link went idle during the conversion: wake before reading
            r.act = ACT_WAKE;
            if (!wk) begin
              r.sts = STS_COMM_ERR;
              take_comm_fault();
            end else begin
              chain_link      = LK_READY;
              chain_last_comm = now;
              chain_entry     = now;
              chain_state     = ST_READ;
            end
          end else begin
            chain_state = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (since_comm >= lim_sleep) begin
          // watchdog: chain assumed asleep, nothing is issued
          chain_cfgd  = 1'b0;
          chain_state = ST_WAKE;
        end else if (since_comm >= lim_idle && !wk) begin
          // wake failed, the read is never tried
          r.act = ACT_WAKE;
          r.sts = STS_COMM_ERR;
          take_comm_fault();
        end else begin
          r.act = ACT_READ;
          if (since_comm >= lim_idle) begin
            r.act           = ACT_WAKE_READ;
            chain_link      = LK_READY;
            chain_last_comm = now;
          end
          if (xf) begin
            chain_link      = LK_READY;
            chain_last_comm = now;
            chain_last_meas = now;
            chain_state     = ST_PROCESS;
          end else begin
            r.sts = STS_COMM_ERR;
            take_comm_fault();
          end
        end
      end
      ST_PROCESS: chain_state = ST_STANDBY;
      ST_SLEEP: begin
        if (since_meas >= lim_period) begin
          chain_cfgd  = 1'b0;
          chain_state = ST_WAKE;
        end
      end
      ST_FAULT: begin
        chain_cfgd  = 1'b0;
        chain_link  = LK_ERROR;
        chain_entry = now;
        chain_state = ST_WAKE;
      end
      default: begin
        // undefined state code
        chain_cfgd  = 1'b0;
        chain_state = ST_FAULT;
        r.sts       = STS_BAD_ST;
      end
    endcase
    r.state = chain_state;
    r.link  = chain_link;
    r.cfgd  = chain_cfgd;
    r.meas  = chain_meas_cnt;
    r.errs  = chain_err_cnt;
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
      mismatch_cnt++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Tick driver: pulls beats from the backlog, holds each until accepted.
  // The prediction is made at the edge where the beat is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_results.push_back(advance_chain(now_ms, wake_ok, xfer_ok));
      end
      // only reload once the held beat is gone; valid never drops early
      if (!in_valid || in_ready) begin
        if (tick_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
          tick_beat_t b;
          b = tick_backlog.pop_front();
          in_valid <= 1'b1;
          now_ms   <= b.now;
          wake_ok  <= b.wake;
          xfer_ok  <= b.xfer;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random backpressure, each taken beat checked against the
  // oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with no tick outstanding, state %0d", $time,
                   next_state);
          mismatch_cnt++;
        end else begin
          tick_result_t want;
          want = pending_results.pop_front();
          check_field("next_state", 32'(want.state), 32'(next_state));
          check_field("link_mode", 32'(want.link), 32'(link_mode));
          check_field("is_configured", 32'(want.cfgd), 32'(is_configured));
          check_field("action", 32'(want.act), 32'(action));
          check_field("status", 32'(want.sts), 32'(status));
          check_field("measure_total", want.meas, measure_total);
          check_field("comm_error_total", want.errs, comm_error_total);
        end
      end
      out_ready <= ($urandom_range(99) >= gap_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_tick(input logic [TIME_W-1:0] t, input logic wk, input logic xf);
    tick_beat_t b;
    b.now  = t;
    b.wake = wk;
    b.xfer = xf;
    tick_backlog.push_back(b);
    ticks_total++;
  endtask

  // Mostly small steps so the short limits trip, with sparse long jumps for
  // the period, sleep and large conversion limits, and a little pure noise.
  task automatic queue_random_ticks(input int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 60)      sim_ms += $urandom_range(6);
      else if (pick < 85) sim_ms += $urandom_range(40, 7);
      else if (pick < 95) sim_ms += $urandom_range(300, 41);
      else if (pick < 98) sim_ms += $urandom_range(70000, 1500);
      queue_tick((pick >= 98) ? $urandom() : sim_ms,
                 $urandom_range(99) < 90, $urandom_range(99) < 90);
    end
  endtask

  // Wait until every tick handed out has come back, then let the pipe settle.
  task automatic drain_results();
    while (results_seen < ticks_total) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Limit writes happen only with the block idle; the predictor follows at
  // the accepting edge.
  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MEASURE_PERIOD: lim_period = val;
      REG_IDLE_TIMEOUT:   lim_idle   = val;
      REG_SLEEP_TIMEOUT:  lim_sleep  = val;
      REG_CONV_TIME:      lim_conv   = val;
      default: ;
    endcase
  endtask

  task automatic write_all_limits(input logic [LIMIT_W-1:0] period, input logic [LIMIT_W-1:0] idle,
                                  input logic [LIMIT_W-1:0] sleep, input logic [LIMIT_W-1:0] conv);
    write_limit(REG_MEASURE_PERIOD, period);
    write_limit(REG_IDLE_TIMEOUT, idle);
    write_limit(REG_SLEEP_TIMEOUT, sleep);
    write_limit(REG_CONV_TIME, conv);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed walk with the reset limits. Comments give the state entered.
    queue_tick(32'd0, 1'b0, 1'b0);   // boot -> wake
    queue_tick(32'd1, 1'b0, 1'b1);   // wake fails -> fault
    queue_tick(32'd2, 1'b1, 1'b1);   // fault -> wake, outcomes ignored
    queue_tick(32'd3, 1'b1, 1'b0);   // wake ok -> configure
    queue_tick(32'd4, 1'b1, 1'b0);   // configure fails: counts cleared, one error
    queue_tick(32'd5, 1'b0, 1'b0);   // fault -> wake
    queue_tick(32'd6, 1'b1, 1'b0);   // wake ok -> configure
    queue_tick(32'd7, 1'b0, 1'b1);   // configure ok -> start
    queue_tick(32'd8, 1'b1, 1'b0);   // start transfer fails -> fault
    queue_tick(32'd9, 1'b1, 1'b1);   // fault -> wake, configured cleared
    queue_tick(32'd10, 1'b1, 1'b1);  // wake ok -> configure
    queue_tick(32'd11, 1'b1, 1'b1);  // configure ok -> start
    queue_tick(32'd12, 1'b0, 1'b1);  // start ok -> wait
    queue_tick(32'd15, 1'b1, 1'b1);  // conversion not done yet
    queue_tick(32'd21, 1'b0, 1'b1);  // wake in wait fails -> fault
    queue_tick(32'd22, 1'b1, 1'b1);  // fault -> wake
    queue_tick(32'd23, 1'b1, 1'b1);  // -> configure
    queue_tick(32'd24, 1'b1, 1'b1);  // -> start
    queue_tick(32'd25, 1'b1, 1'b1);  // -> wait
    queue_tick(32'd34, 1'b1, 1'b1);  // wake in wait ok -> read
    queue_tick(32'd40, 1'b0, 1'b1);  // wake before read fails, read skipped
    queue_tick(32'd41, 1'b1, 1'b1);  // fault -> wake
    queue_tick(32'd42, 1'b1, 1'b1);  // -> configure
    queue_tick(32'd43, 1'b1, 1'b1);  // -> start
    queue_tick(32'd44, 1'b1, 1'b1);  // -> wait
    queue_tick(32'd53, 1'b1, 1'b1);  // -> read
    queue_tick(32'd60, 1'b1, 1'b1);  // wake then read -> process
    queue_tick(32'd61, 1'b0, 1'b0);  // -> standby
    queue_tick(32'hFFFF_FFFF, 1'b1, 1'b1);  // standby, sleep timeout -> wake
    sim_ms = 32'hFFFF_FFFF;
    queue_random_ticks(220);
    drain_results();

    // Every limit at its floor
    write_all_limits(16'd0, 16'd0, 16'd0, 16'd0);
    queue_random_ticks(150);
    drain_results();

    // Idle and sleep limits at their maximum: mostly plain reads and direct standby restarts
    write_all_limits(16'd20, 16'hFFFF, 16'hFFFF, 16'd3);
    queue_random_ticks(250);
    drain_results();

    // Long conversion and period, short idle and sleep, clock about to wrap
    write_all_limits(16'hFFFF, 16'd3, 16'd300, 16'hFFFF);
    sim_ms = 32'hFFFF_F000;
    queue_random_ticks(150);
    drain_results();

    // Random limits, run with no idling on either side
    write_all_limits(LIMIT_W'($urandom_range(200)), LIMIT_W'($urandom_range(20)),
                     LIMIT_W'($urandom_range(5000)), LIMIT_W'($urandom_range(15)));
    write_limit(REG_UNMAPPED, LIMIT_W'($urandom_range(16'hFFFF)));
    gap_pct = 0;
    queue_random_ticks(250);
    drain_results();

    // Back to the reset limits with idling
    gap_pct = 36;
    write_all_limits(MEASURE_PERIOD_RST, IDLE_TIMEOUT_RST, SLEEP_TIMEOUT_RST, CONV_TIME_RST);
    queue_random_ticks(230);
    drain_results();

    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("monitor_link_service_sequencer_tb passed");
    end else begin
      if (pending_results.size() != 0)
        $display("%0t: %0d results never arrived", $time, pending_results.size());
      $display("monitor_link_service_sequencer_tb failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("monitor_link_service_sequencer_tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mlss_pkg.sv
sv/mlss_cfg_regs.sv
sv/mlss_step.sv
sv/monitor_link_service_sequencer.sv
sv/mlss_checker.sv
tb/monitor_link_service_sequencer_tb.sv
